// ===== rtl/kpc_pkg.sv =====
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared widths, codes, register indexes and types of the key press
// classifier queue.
// ----------------------------------------------------------------------------
package kpc_pkg;

   localparam int CNT_W     = 12;
   localparam int LEVEL_W   = 3;
   localparam int SEL_W     = 2;
   localparam int CODE_W    = 2;
   localparam int CSR_IDX_W = 3;

   // Commands.
   localparam logic CMD_TICK    = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   // Key classes, also used as event codes.
   localparam logic [CODE_W-1:0] CLS_UP    = 2'd0;
   localparam logic [CODE_W-1:0] CLS_SHORT = 2'd1;
   localparam logic [CODE_W-1:0] CLS_LONG  = 2'd2;
   localparam logic [CODE_W-1:0] EVT_NONE  = 2'd0;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_PRESS_LIMIT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_STEP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SHORT_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_LOW        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_THRESHOLD  = 3'd4;

   // Register reset values.
   localparam logic [CNT_W-1:0] RST_PRESS_LIMIT     = 12'd2000;
   localparam logic [CNT_W-1:0] RST_RELEASE_STEP    = 12'd10;
   localparam logic [CNT_W-1:0] RST_SHORT_THRESHOLD = 12'd50;
   localparam logic [CNT_W-1:0] RST_HOLD_LOW        = 12'd800;
   localparam logic [CNT_W-1:0] RST_LONG_THRESHOLD  = 12'd1000;

   typedef struct packed {
      logic [CNT_W-1:0] press_limit;
      logic [CNT_W-1:0] release_step;
      logic [CNT_W-1:0] short_threshold;
      logic [CNT_W-1:0] hold_low;
      logic [CNT_W-1:0] long_threshold;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
   } push_type;

endpackage

// ===== rtl/kpc_if.sv =====
// ----------------------------------------------------------------------------
// kpc_req_if / kpc_rsp_if
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface kpc_req_if;
   logic                       valid;
   logic                       ready;
   logic                       command;
   logic [kpc_pkg::LEVEL_W-1:0] key_levels;
   logic [kpc_pkg::SEL_W-1:0]   key_select;

   modport source (output valid, command, key_levels, key_select, input ready);
   modport sink   (input valid, command, key_levels, key_select, output ready);
endinterface

interface kpc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [kpc_pkg::CODE_W-1:0] event_code;
   logic [kpc_pkg::SEL_W-1:0]  event_key;

   modport source (output valid, event_code, event_key, input ready);
   modport sink   (input valid, event_code, event_key, output ready);
endinterface

// ===== rtl/kpc_key.sv =====
// ----------------------------------------------------------------------------
// kpc_key
// Integrating counter and classifier of one key; raises an event push.
// ----------------------------------------------------------------------------
module kpc_key (
   input  logic              clock,
   input  logic              reset,
   input  kpc_pkg::cfg_type  cfg,
   input  logic              tick,
   input  logic              released,
   output kpc_pkg::push_type push
);

   logic [kpc_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [kpc_pkg::CODE_W-1:0] class_ff, class_in;

   always_comb begin
      if (!released) begin
         count_in = (count_ff >= cfg.press_limit) ? cfg.press_limit
                                                  : count_ff + 1'b1;
      end else begin
         count_in = (count_ff <= cfg.release_step) ? '0
                                                   : count_ff - cfg.release_step;
         // A release that lands in the hold band drops the key at once.
         if (count_in >= cfg.hold_low && count_in < cfg.long_threshold) begin
            count_in = '0;
         end
      end

      if (count_in < cfg.short_threshold) begin
         class_in = kpc_pkg::CLS_UP;
      end else if (count_in < cfg.hold_low) begin
         class_in = kpc_pkg::CLS_SHORT;
      end else if (count_in >= cfg.long_threshold) begin
         class_in = kpc_pkg::CLS_LONG;
      end else begin
         class_in = class_ff;
      end

      push.valid = 1'b0;
      push.code  = kpc_pkg::CLS_SHORT;
      if (tick) begin
         if (class_ff == kpc_pkg::CLS_SHORT && class_in == kpc_pkg::CLS_UP) begin
            push.valid = 1'b1;
         end else if (class_in == kpc_pkg::CLS_LONG) begin
            push.valid = 1'b1;
            push.code  = kpc_pkg::CLS_LONG;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         class_ff <= kpc_pkg::CLS_UP;
      end else if (tick) begin
         count_ff <= count_in;
         class_ff <= class_in;
      end
   end

endmodule

// ===== rtl/kpc_ring.sv =====
// ----------------------------------------------------------------------------
// kpc_ring
// Event ring of one key: a small memory with head and tail pointers.
// The registered read port always holds the entry at the head.
// ----------------------------------------------------------------------------
module kpc_ring #(
   parameter int RING_DEPTH = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  kpc_pkg::push_type          push,
   input  logic                       pop,
   output logic                       empty,
   output logic [kpc_pkg::CODE_W-1:0] head_code
);

   localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST = PTR_W'(RING_DEPTH - 1);

   logic [kpc_pkg::CODE_W-1:0] mem [RING_DEPTH];
   logic [kpc_pkg::CODE_W-1:0] rd_ff;
   logic [PTR_W-1:0]           head_ff, head_in;
   logic [PTR_W-1:0]           tail_ff, tail_in;
   logic [PTR_W-1:0]           tail_next, head_next;

   assign tail_next = (tail_ff == LAST) ? '0 : tail_ff + 1'b1;
   assign head_next = (head_ff == LAST) ? '0 : head_ff + 1'b1;
   assign empty     = (head_ff == tail_ff);
   assign head_code = rd_ff;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (push.valid) begin
         tail_in = tail_next;
         // A full ring drops its oldest item.
         if (tail_next == head_ff) begin
            head_in = head_next;
         end
      end else if (pop && !empty) begin
         head_in = head_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   // Write-first: a write to the address being read shows up at once.
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem[tail_ff] <= push.code;
      end
      if (push.valid && tail_ff == head_in) begin
         rd_ff <= push.code;
      end else begin
         rd_ff <= mem[head_in];
      end
   end

endmodule

// ===== rtl/key_press_classifier_queue.sv =====
// ----------------------------------------------------------------------------
// key_press_classifier_queue
// Debounces and classifies keys into short and long presses and queues the
// resulting events in one ring per key.
//
// Request channel (req_ch): a scan tick carries the key levels (0 means
// pressed) and updates every key; a dequeue names a key and returns its
// oldest event. Only dequeues produce a response item on rsp_ch, with the
// event code (none, short, long) and the key echoed.
// Registers are written on the csr_ port; the user must do so only while the
// block is idle, as the block does not enforce it. Timing: a request is taken
// into an input register and processed while there; the response of a
// dequeue is then written into the output register. One item is taken per
// cycle as long as the response side keeps up.
// When rsp_ch stalls, ticks still flow; a dequeue waits in the input
// register and req_ch holds ready low behind it.
// Reset clears counters, classes, ring pointers and loads register defaults;
// ring contents are not cleared.
// ----------------------------------------------------------------------------
module key_press_classifier_queue #(
   parameter int KEY_COUNT  = 3,
   parameter int RING_DEPTH = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   kpc_req_if.sink                       req_ch,
   kpc_rsp_if.source                     rsp_ch,
   input  logic                          csr_write_enable,
   input  logic [kpc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kpc_pkg::CNT_W-1:0]     csr_wdata
);

   kpc_pkg::cfg_type cfg_ff;

   logic                         s1_valid_ff;
   logic                         s1_cmd_ff;
   logic [kpc_pkg::LEVEL_W-1:0]  s1_levels_ff;
   logic [kpc_pkg::SEL_W-1:0]    s1_sel_ff;
   logic                         s1_fire;

   logic                         out_valid_ff, out_valid_in;
   logic [kpc_pkg::CODE_W-1:0]   out_code_ff, out_code_in;
   logic [kpc_pkg::SEL_W-1:0]    out_key_ff;

   logic                         tick, dequeue;
   logic [KEY_COUNT-1:0]         released, pop, empty, selected;
   kpc_pkg::push_type            push [KEY_COUNT];
   logic [kpc_pkg::CODE_W-1:0]   head_code [KEY_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_limit     <= kpc_pkg::RST_PRESS_LIMIT;
         cfg_ff.release_step    <= kpc_pkg::RST_RELEASE_STEP;
         cfg_ff.short_threshold <= kpc_pkg::RST_SHORT_THRESHOLD;
         cfg_ff.hold_low        <= kpc_pkg::RST_HOLD_LOW;
         cfg_ff.long_threshold  <= kpc_pkg::RST_LONG_THRESHOLD;
      end else if (csr_write_enable) begin
         case (csr_index)
            kpc_pkg::REG_PRESS_LIMIT:     cfg_ff.press_limit     <= csr_wdata;
            kpc_pkg::REG_RELEASE_STEP:    cfg_ff.release_step    <= csr_wdata;
            kpc_pkg::REG_SHORT_THRESHOLD: cfg_ff.short_threshold <= csr_wdata;
            kpc_pkg::REG_HOLD_LOW:        cfg_ff.hold_low        <= csr_wdata;
            kpc_pkg::REG_LONG_THRESHOLD:  cfg_ff.long_threshold  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A tick never needs the output register, so it always moves on.
   assign s1_fire = s1_valid_ff &&
                    (s1_cmd_ff == kpc_pkg::CMD_TICK || !out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_fire;
   assign tick    = s1_fire && (s1_cmd_ff == kpc_pkg::CMD_TICK);
   assign dequeue = s1_fire && (s1_cmd_ff == kpc_pkg::CMD_DEQUEUE);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         s1_cmd_ff    <= req_ch.command;
         s1_levels_ff <= req_ch.key_levels;
         s1_sel_ff    <= req_ch.key_select;
      end
   end

   genvar k;
   generate
      for (k = 0; k < KEY_COUNT; k++) begin : g_key
         // Keys without a level bit read as pressed.
         if (k < kpc_pkg::LEVEL_W) begin : g_lvl
            assign released[k] = s1_levels_ff[k];
         end else begin : g_nolvl
            assign released[k] = 1'b0;
         end

         assign selected[k] = (int'(s1_sel_ff) == k);
         assign pop[k]      = dequeue && selected[k] && !empty[k];

         kpc_key u_key (
            .clock    (clock),
            .reset    (reset),
            .cfg      (cfg_ff),
            .tick     (tick),
            .released (released[k]),
            .push     (push[k])
         );

         kpc_ring #(
            .RING_DEPTH (RING_DEPTH)
         ) u_ring (
            .clock     (clock),
            .reset     (reset),
            .push      (push[k]),
            .pop       (pop[k]),
            .empty     (empty[k]),
            .head_code (head_code[k])
         );
      end
   endgenerate

   always_comb begin
      out_code_in = kpc_pkg::EVT_NONE;
      for (int i = 0; i < KEY_COUNT; i++) begin
         if (selected[i] && !empty[i]) begin
            out_code_in = head_code[i];
         end
      end
   end

   always_comb begin
      if (dequeue) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dequeue) begin
         out_code_ff <= out_code_in;
         out_key_ff  <= s1_sel_ff;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.event_code = out_code_ff;
   assign rsp_ch.event_key  = out_key_ff;

endmodule
